// ===== src/spq_pkg.sv =====
// Shared types and sizes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int PRIO_W    = 4;
    localparam int COUNT_W   = $clog2(DEPTH + 1);

    // Stream packing widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = PAYLOAD_W + PRIO_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 1 + PAYLOAD_W + PRIO_W + 1 + PAYLOAD_W + PRIO_W + COUNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Request kinds carried on the input tuser bit.
    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    // Result status codes carried on the output tuser bits.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One queue slot.
    typedef struct packed {
        logic                 valid;
        logic [PAYLOAD_W-1:0] payload;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    // Shift control broadcast to every cell.
    typedef struct packed {
        logic enq;
        logic deq;
    } shift_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::shift_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     left_entry,
    input  logic                left_displace,
    input  spq_pkg::entry_t     right_entry,
    output logic                displace,
    output spq_pkg::entry_t     entry,
    output spq_pkg::entry_t     entry_next
);
    import spq_pkg::*;

    entry_t slot_reg;
    entry_t slot_next;

    // The new entry goes ahead of this slot when the slot is empty or holds a
    // strictly greater priority; equal priorities stay in front.
    assign displace = !slot_reg.valid || (slot_reg.prio > new_entry.prio);

    // Keep, shift towards the back, take the new entry, or shift to the front.
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.enq)
        begin
            if (displace)
            begin
                slot_next = left_displace ? left_entry : new_entry;
            end
        end
        else if (ctrl.deq)
        begin
            slot_next = right_entry;
        end
    end

    // Slot register; reset leaves the slot empty and its contents cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign entry      = slot_reg;
    assign entry_next = slot_next;

endmodule

// ===== src/stable_priority_queue.sv =====
// Top level of the stable priority queue: a row of sorted cells and the result register.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  s_*      | in        | payload, priority_req, zero fill           | cmd
//  m_*      | out       | popped_valid, popped_payload, popped_priority,| status
//           |           | front_valid, front_payload, front_priority, |
//           |           | occupancy, zero fill                        |
//
// Every cell compares its priority with the new one in parallel and shifts one place,
// so one request per cycle is sustained while each result is taken on m_tready.
// The result is registered; a new request is taken while the current result is read.
// Reset empties the queue and clears the result valid flag (the result data is not reset); no clearing pass is needed.
// While the result waits on m_tready, s_tready stays low and the queue holds.
`timescale 1ns / 1ps

module stable_priority_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spq_pkg::S_DATA_W-1:0] s_tdata,  // payload, priority_req
    input  logic                         s_tuser,  // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spq_pkg::M_DATA_W-1:0] m_tdata,  // popped_valid, popped_payload,
                                                   // popped_priority, front_valid,
                                                   // front_payload, front_priority,
                                                   // occupancy
    output logic [1:0]                   m_tuser   // status
);
    import spq_pkg::*;

    logic                 req_fire;
    logic                 is_deq;
    logic                 full;
    logic                 empty;
    shift_ctrl_t          ctrl;
    entry_t               new_entry;
    entry_t               cur   [DEPTH];
    entry_t               nxt   [DEPTH];
    logic                 disp  [DEPTH];
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    status_t              status;
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [M_DATA_W-1:0]  out_data_next;
    status_t              out_status_reg;
    entry_t               popped;
    entry_t               front;

    // Request decode.
    assign s_tready  = !out_valid_reg || m_tready;
    assign req_fire  = s_tvalid && s_tready;
    assign is_deq    = (cmd_t'(s_tuser) == CMD_DEQ);
    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ctrl.enq  = req_fire && !is_deq && !full;
    assign ctrl.deq  = req_fire && is_deq && !empty;

    assign new_entry.valid   = 1'b1;
    assign new_entry.payload = s_tdata[PAYLOAD_W-1:0];
    assign new_entry.prio    = s_tdata[PAYLOAD_W +: PRIO_W];

    // Row of cells: front at index 0.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_d;

            if (gi == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_d = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cur[gi-1];
                assign left_d = disp[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cur[gi+1];
            end

            spq_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .new_entry     (new_entry),
                .left_entry    (left_e),
                .left_displace (left_d),
                .right_entry   (right_e),
                .displace      (disp[gi]),
                .entry         (cur[gi]),
                .entry_next    (nxt[gi])
            );
        end
    endgenerate

    // Occupancy and status.
    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        if (ctrl.enq)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        if (!is_deq && full)
        begin
            status = ST_FULL;
        end
        else if (is_deq && empty)
        begin
            status = ST_EMPTY;
        end
    end

    // Result assembly: popped slot before the step, front slot after it.
    always_comb
    begin
        popped = ctrl.deq ? cur[0] : '0;
        front  = nxt[0].valid ? nxt[0] : '0;
        out_data_next = '0;
        out_data_next[M_DATA_BITS-1:0] = {count_next,
                                          front.prio, front.payload, front.valid,
                                          popped.prio, popped.payload, popped.valid};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule
